[rtl/hse_pkg.sv]
// Shared types and constants of the heap sort engine.
// Holds the micro-operation codes, jump conditions, control word and status struct.
// Depends on nothing; every other file of the block but hse_ram refers to it.
`default_nettype none

package hse_pkg;

    localparam int VALUE_W       = 32;
    localparam int DEPTH_DEFAULT = 64;
    localparam int STEP_W        = 5;

    typedef logic [STEP_W-1:0] step_t;

    // Datapath operation selected by the current control word.
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_INIT,
        OP_BUILD_NEXT,
        OP_RD_CUR,
        OP_CAP_CUR,
        OP_RD_LC,
        OP_CMP_LC,
        OP_CMP_RC,
        OP_WR_CUR,
        OP_WR_BIG,
        OP_RD_ROOT,
        OP_RD_END,
        OP_SWAP_A,
        OP_SWAP_B,
        OP_EMIT_INIT,
        OP_RD_K,
        OP_PRESENT,
        OP_EMIT_NEXT,
        OP_CLEAR
    } op_t;

    // Condition that decides whether the control word's jump is taken.
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_LAST_ACC,
        COND_CNT_LT2,
        COND_K_ZERO,
        COND_LC_OOB,
        COND_RC_OOB,
        COND_BIG_EQ_CUR,
        COND_IN_BUILD,
        COND_LEN_LE1,
        COND_OUT_STALL,
        COND_EMIT_DONE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  neg;
        step_t target;
    } uword_t;

    typedef struct packed {
        logic last_acc;
        logic cnt_lt2;
        logic k_zero;
        logic lc_oob;
        logic rc_oob;
        logic big_eq_cur;
        logic in_build;
        logic len_le1;
        logic out_stall;
        logic emit_done;
    } status_t;

endpackage

`default_nettype wire

[rtl/hse_in_if.sv]
// Input channel of the heap sort engine: valid/ready handshake with the element payload.
// Depends on hse_pkg for the value width.
`default_nettype none

interface hse_in_if;

    logic                            valid;
    logic                            ready;
    logic [hse_pkg::VALUE_W-1:0]     value;
    logic                            last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);

endinterface

`default_nettype wire

[rtl/hse_out_if.sv]
// Result channel of the heap sort engine: valid/ready handshake with the sorted payload.
// Depends on hse_pkg for the value width.
`default_nettype none

interface hse_out_if;

    logic                            valid;
    logic                            ready;
    logic [hse_pkg::VALUE_W-1:0]     sorted_value;
    logic                            last_result;
    logic                            overflow;

    modport source (output valid, output sorted_value, output last_result, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_result, input overflow,
                    output ready);

endinterface

`default_nettype wire

[rtl/heap_sort_engine.sv]
// Heap sort engine top level: element store, datapath registers and result register.
// Depends on hse_pkg, hse_in_if, hse_out_if, hse_ram and hse_sequencer.
//
// The engine takes signed 32-bit elements, one per transaction, into a store of DEPTH
// entries until a transaction marked last_item arrives; elements beyond DEPTH are discarded
// and every result of that data set then carries overflow. The last transaction starts an
// in-place heapsort run by a microcoded sequencer over a single-port-read store with
// registered read data: each sift-down level reads the children, compares each with the
// larger value so far and, if a child won, writes back two entries; the parent is read once
// per sift-down. Results are then read back in ascending order, each held until the sink is
// ready, with last_result on the final one. No input is taken from the last element's
// transaction until the final result has been delivered.
`default_nettype none

module heap_sort_engine #(
    parameter int DEPTH = hse_pkg::DEPTH_DEFAULT
) (
    input wire logic clk,
    input wire logic rst_n,
    hse_in_if.sink   items,
    hse_out_if.source results
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;
    localparam int IW = AW + 2;
    localparam int VW = hse_pkg::VALUE_W;

    hse_pkg::op_t     op;
    hse_pkg::status_t status;

    logic [CW-1:0] cnt_reg,  cnt_next;
    logic          drop_reg, drop_next;
    logic [CW-1:0] len_reg,  len_next;
    logic [AW-1:0] k_reg,    k_next;
    logic [AW-1:0] cur_reg,  cur_next;
    logic [AW-1:0] big_reg,  big_next;
    logic          build_reg, build_next;
    logic          out_valid_reg, out_valid_next;

    logic [VW-1:0] cur_val_reg,   cur_val_next;
    logic [VW-1:0] big_val_reg,   big_val_next;
    logic [VW-1:0] out_value_reg, out_value_next;
    logic          out_last_reg,  out_last_next;
    logic          out_ovf_reg,   out_ovf_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [VW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [VW-1:0] ram_rdata;

    logic          in_acc;
    logic          out_acc;
    logic [IW-1:0] lc_idx;
    logic [IW-1:0] rc_idx;
    logic [IW-1:0] len_ext;
    logic [AW-1:0] end_idx;
    logic          k_is_last;

    assign in_acc    = items.valid && items.ready;
    assign out_acc   = results.valid && results.ready;
    assign lc_idx    = {1'b0, cur_reg, 1'b1};
    assign rc_idx    = lc_idx + 1'b1;
    assign len_ext   = {1'b0, len_reg};
    assign end_idx   = AW'(len_reg - 1'b1);
    assign k_is_last = (({1'b0, k_reg} + 1'b1) == cnt_reg);

    assign status.last_acc   = in_acc && items.last_item;
    assign status.cnt_lt2    = (cnt_reg[CW-1:1] == '0);
    assign status.k_zero     = (k_reg == '0);
    assign status.lc_oob     = (lc_idx >= len_ext);
    assign status.rc_oob     = (rc_idx >= len_ext);
    assign status.big_eq_cur = (big_reg == cur_reg);
    assign status.in_build   = build_reg;
    assign status.len_le1    = (len_reg[CW-1:1] == '0);
    assign status.out_stall  = out_valid_reg && !results.ready;
    assign status.emit_done  = k_is_last;

    hse_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .op     (op)
    );

    hse_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign items.ready          = (op == hse_pkg::OP_LOAD);
    assign results.valid        = out_valid_reg;
    assign results.sorted_value = out_value_reg;
    assign results.last_result  = out_last_reg;
    assign results.overflow     = out_ovf_reg;

    always_comb
    begin
        cnt_next       = cnt_reg;
        drop_next      = drop_reg;
        len_next       = len_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        big_next       = big_reg;
        build_next     = build_reg;
        cur_val_next   = cur_val_reg;
        big_val_next   = big_val_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg && !out_acc;

        ram_we    = 1'b0;
        ram_waddr = cur_reg;
        ram_wdata = big_val_reg;
        ram_raddr = cur_reg;

        unique case (op)
            hse_pkg::OP_LOAD:
            begin
                if (in_acc)
                begin
                    if (cnt_reg < CW'(DEPTH))
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cnt_reg[AW-1:0];
                        ram_wdata = items.value;
                        cnt_next  = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
            end
            hse_pkg::OP_INIT:
            begin
                len_next   = cnt_reg;
                k_next     = cnt_reg[CW-1:1];
                build_next = 1'b1;
            end
            hse_pkg::OP_BUILD_NEXT:
            begin
                k_next   = k_reg - 1'b1;
                cur_next = k_reg - 1'b1;
            end
            hse_pkg::OP_RD_CUR:
            begin
                ram_raddr = cur_reg;
            end
            hse_pkg::OP_CAP_CUR:
            begin
                cur_val_next = ram_rdata;
                big_val_next = ram_rdata;
                big_next     = cur_reg;
            end
            hse_pkg::OP_RD_LC:
            begin
                ram_raddr = lc_idx[AW-1:0];
            end
            hse_pkg::OP_CMP_LC:
            begin
                ram_raddr = rc_idx[AW-1:0];
                if ($signed(ram_rdata) > $signed(big_val_reg))
                begin
                    big_next     = lc_idx[AW-1:0];
                    big_val_next = ram_rdata;
                end
            end
            hse_pkg::OP_CMP_RC:
            begin
                if ($signed(ram_rdata) > $signed(big_val_reg))
                begin
                    big_next     = rc_idx[AW-1:0];
                    big_val_next = ram_rdata;
                end
            end
            hse_pkg::OP_WR_CUR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = big_val_reg;
            end
            hse_pkg::OP_WR_BIG:
            begin
                // The sinking value moves down; it stays the one to beat on the next level.
                ram_we       = 1'b1;
                ram_waddr    = big_reg;
                ram_wdata    = cur_val_reg;
                cur_next     = big_reg;
                big_val_next = cur_val_reg;
            end
            hse_pkg::OP_RD_ROOT:
            begin
                ram_raddr  = '0;
                build_next = 1'b0;
            end
            hse_pkg::OP_RD_END:
            begin
                ram_raddr    = end_idx;
                cur_val_next = ram_rdata;
            end
            hse_pkg::OP_SWAP_A:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = ram_rdata;
            end
            hse_pkg::OP_SWAP_B:
            begin
                ram_we    = 1'b1;
                ram_waddr = end_idx;
                ram_wdata = cur_val_reg;
                len_next  = len_reg - 1'b1;
                cur_next  = '0;
            end
            hse_pkg::OP_EMIT_INIT:
            begin
                k_next = '0;
            end
            hse_pkg::OP_RD_K:
            begin
                ram_raddr = k_reg;
            end
            hse_pkg::OP_PRESENT:
            begin
                out_valid_next = 1'b1;
                out_value_next = ram_rdata;
                out_last_next  = k_is_last;
                out_ovf_next   = drop_reg;
            end
            hse_pkg::OP_EMIT_NEXT:
            begin
                k_next = k_reg + 1'b1;
            end
            hse_pkg::OP_CLEAR:
            begin
                cnt_next  = '0;
                drop_next = 1'b0;
            end
            hse_pkg::OP_NOP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            drop_reg      <= 1'b0;
            len_reg       <= '0;
            k_reg         <= '0;
            cur_reg       <= '0;
            big_reg       <= '0;
            build_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            drop_reg      <= drop_next;
            len_reg       <= len_next;
            k_reg         <= k_next;
            cur_reg       <= cur_next;
            big_reg       <= big_next;
            build_reg     <= build_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_val_reg   <= cur_val_next;
        big_val_reg   <= big_val_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // The element count never exceeds the store size.
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(DEPTH))
        else $error("element count beyond store size");

    // No element is taken while a result is still on offer.
    assert property (@(posedge clk) disable iff (!rst_n) in_acc |-> !out_valid_reg)
        else $error("input transaction during emission");

    // A last element always hands control to the sort.
    assert property (@(posedge clk) disable iff (!rst_n)
                     in_acc && items.last_item |=> op == hse_pkg::OP_INIT)
        else $error("sort did not start after last element");

    // Each delivered result moves the read-back index on.
    assert property (@(posedge clk) disable iff (!rst_n)
                     out_acc |=> op == hse_pkg::OP_EMIT_NEXT)
        else $error("result transaction outside emission step");

endmodule

`default_nettype wire

[rtl/hse_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the element store of the heap sort engine.
`default_nettype none

module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/hse_sequencer.sv]
// Microcode sequencer of the heap sort engine: step counter, control store and jump logic.
// Depends on hse_pkg for the control word, operation, condition and status types.
`default_nettype none

module hse_sequencer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire hse_pkg::status_t status,
    output hse_pkg::op_t          op
);

    localparam hse_pkg::step_t STEP_LOAD        = hse_pkg::step_t'(0);
    localparam hse_pkg::step_t STEP_INIT        = hse_pkg::step_t'(1);
    localparam hse_pkg::step_t STEP_BUILD_TEST  = hse_pkg::step_t'(2);
    localparam hse_pkg::step_t STEP_BUILD_NEXT  = hse_pkg::step_t'(3);
    localparam hse_pkg::step_t STEP_SIFT        = hse_pkg::step_t'(4);
    localparam hse_pkg::step_t STEP_CAP_CUR     = hse_pkg::step_t'(5);
    localparam hse_pkg::step_t STEP_RD_LC       = hse_pkg::step_t'(6);
    localparam hse_pkg::step_t STEP_CMP_LC      = hse_pkg::step_t'(7);
    localparam hse_pkg::step_t STEP_CMP_RC      = hse_pkg::step_t'(8);
    localparam hse_pkg::step_t STEP_SWAP_TEST   = hse_pkg::step_t'(9);
    localparam hse_pkg::step_t STEP_WR_CUR      = hse_pkg::step_t'(10);
    localparam hse_pkg::step_t STEP_WR_BIG      = hse_pkg::step_t'(11);
    localparam hse_pkg::step_t STEP_SIFT_RET    = hse_pkg::step_t'(12);
    localparam hse_pkg::step_t STEP_EXTRACT     = hse_pkg::step_t'(13);
    localparam hse_pkg::step_t STEP_RD_ROOT     = hse_pkg::step_t'(14);
    localparam hse_pkg::step_t STEP_RD_END      = hse_pkg::step_t'(15);
    localparam hse_pkg::step_t STEP_SWAP_A      = hse_pkg::step_t'(16);
    localparam hse_pkg::step_t STEP_SWAP_B      = hse_pkg::step_t'(17);
    localparam hse_pkg::step_t STEP_EMIT_INIT   = hse_pkg::step_t'(18);
    localparam hse_pkg::step_t STEP_RD_K        = hse_pkg::step_t'(19);
    localparam hse_pkg::step_t STEP_PRESENT     = hse_pkg::step_t'(20);
    localparam hse_pkg::step_t STEP_WAIT        = hse_pkg::step_t'(21);
    localparam hse_pkg::step_t STEP_EMIT_NEXT   = hse_pkg::step_t'(22);
    localparam hse_pkg::step_t STEP_CLEAR       = hse_pkg::step_t'(23);

    function automatic hse_pkg::uword_t uw(hse_pkg::op_t o, hse_pkg::cond_t c, logic n,
                                           hse_pkg::step_t t);
        hse_pkg::uword_t w;
        w.op     = o;
        w.cond   = c;
        w.neg    = n;
        w.target = t;
        return w;
    endfunction

    // Control store. A jump is taken when the selected condition, optionally inverted,
    // holds; otherwise the step counter advances by one.
    function automatic hse_pkg::uword_t rom(hse_pkg::step_t s);
        hse_pkg::uword_t w;
        unique case (s)
            STEP_LOAD:       w = uw(hse_pkg::OP_LOAD, hse_pkg::COND_LAST_ACC, 1'b1, STEP_LOAD);
            STEP_INIT:       w = uw(hse_pkg::OP_INIT, hse_pkg::COND_CNT_LT2, 1'b0,
                                    STEP_EMIT_INIT);
            STEP_BUILD_TEST: w = uw(hse_pkg::OP_NOP, hse_pkg::COND_K_ZERO, 1'b0, STEP_EXTRACT);
            STEP_BUILD_NEXT: w = uw(hse_pkg::OP_BUILD_NEXT, hse_pkg::COND_ALWAYS, 1'b0,
                                    STEP_SIFT);
            STEP_SIFT:       w = uw(hse_pkg::OP_RD_CUR, hse_pkg::COND_NEVER, 1'b0, STEP_LOAD);
            STEP_CAP_CUR:    w = uw(hse_pkg::OP_CAP_CUR, hse_pkg::COND_NEVER, 1'b0, STEP_LOAD);
            STEP_RD_LC:      w = uw(hse_pkg::OP_RD_LC, hse_pkg::COND_LC_OOB, 1'b0,
                                    STEP_SIFT_RET);
            STEP_CMP_LC:     w = uw(hse_pkg::OP_CMP_LC, hse_pkg::COND_RC_OOB, 1'b0,
                                    STEP_SWAP_TEST);
            STEP_CMP_RC:     w = uw(hse_pkg::OP_CMP_RC, hse_pkg::COND_NEVER, 1'b0, STEP_LOAD);
            STEP_SWAP_TEST:  w = uw(hse_pkg::OP_NOP, hse_pkg::COND_BIG_EQ_CUR, 1'b0,
                                    STEP_SIFT_RET);
            STEP_WR_CUR:     w = uw(hse_pkg::OP_WR_CUR, hse_pkg::COND_NEVER, 1'b0, STEP_LOAD);
            STEP_WR_BIG:     w = uw(hse_pkg::OP_WR_BIG, hse_pkg::COND_ALWAYS, 1'b0, STEP_RD_LC);
            STEP_SIFT_RET:   w = uw(hse_pkg::OP_NOP, hse_pkg::COND_IN_BUILD, 1'b0,
                                    STEP_BUILD_TEST);
            STEP_EXTRACT:    w = uw(hse_pkg::OP_NOP, hse_pkg::COND_LEN_LE1, 1'b0,
                                    STEP_EMIT_INIT);
            STEP_RD_ROOT:    w = uw(hse_pkg::OP_RD_ROOT, hse_pkg::COND_NEVER, 1'b0, STEP_LOAD);
            STEP_RD_END:     w = uw(hse_pkg::OP_RD_END, hse_pkg::COND_NEVER, 1'b0, STEP_LOAD);
            STEP_SWAP_A:     w = uw(hse_pkg::OP_SWAP_A, hse_pkg::COND_NEVER, 1'b0, STEP_LOAD);
            STEP_SWAP_B:     w = uw(hse_pkg::OP_SWAP_B, hse_pkg::COND_ALWAYS, 1'b0, STEP_SIFT);
            STEP_EMIT_INIT:  w = uw(hse_pkg::OP_EMIT_INIT, hse_pkg::COND_NEVER, 1'b0,
                                    STEP_LOAD);
            STEP_RD_K:       w = uw(hse_pkg::OP_RD_K, hse_pkg::COND_NEVER, 1'b0, STEP_LOAD);
            STEP_PRESENT:    w = uw(hse_pkg::OP_PRESENT, hse_pkg::COND_NEVER, 1'b0, STEP_LOAD);
            STEP_WAIT:       w = uw(hse_pkg::OP_NOP, hse_pkg::COND_OUT_STALL, 1'b0, STEP_WAIT);
            STEP_EMIT_NEXT:  w = uw(hse_pkg::OP_EMIT_NEXT, hse_pkg::COND_EMIT_DONE, 1'b1,
                                    STEP_RD_K);
            STEP_CLEAR:      w = uw(hse_pkg::OP_CLEAR, hse_pkg::COND_ALWAYS, 1'b0, STEP_LOAD);
            default:         w = uw(hse_pkg::OP_NOP, hse_pkg::COND_ALWAYS, 1'b0, STEP_LOAD);
        endcase
        return w;
    endfunction

    hse_pkg::step_t  step_reg;
    hse_pkg::step_t  step_next;
    hse_pkg::uword_t word;
    logic            cond_hit;

    assign word = rom(step_reg);
    assign op   = word.op;

    always_comb
    begin
        unique case (word.cond)
            hse_pkg::COND_NEVER:      cond_hit = 1'b0;
            hse_pkg::COND_ALWAYS:     cond_hit = 1'b1;
            hse_pkg::COND_LAST_ACC:   cond_hit = status.last_acc;
            hse_pkg::COND_CNT_LT2:    cond_hit = status.cnt_lt2;
            hse_pkg::COND_K_ZERO:     cond_hit = status.k_zero;
            hse_pkg::COND_LC_OOB:     cond_hit = status.lc_oob;
            hse_pkg::COND_RC_OOB:     cond_hit = status.rc_oob;
            hse_pkg::COND_BIG_EQ_CUR: cond_hit = status.big_eq_cur;
            hse_pkg::COND_IN_BUILD:   cond_hit = status.in_build;
            hse_pkg::COND_LEN_LE1:    cond_hit = status.len_le1;
            hse_pkg::COND_OUT_STALL:  cond_hit = status.out_stall;
            hse_pkg::COND_EMIT_DONE:  cond_hit = status.emit_done;
            default:                  cond_hit = 1'b0;
        endcase

        if (cond_hit ^ word.neg)
        begin
            step_next = word.target;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_LOAD;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire
